[rtl/sgvs_pkg.sv]
// Shared types and constants of the staggered grid velocity sampler.
// No dependencies; imported by sgvs_div and the top level.
`default_nettype none
package sgvs_pkg;
  localparam int DefGridW = 64;
  localparam int DefGridH = 64;
  localparam logic [30:0] CellSizeReset = 31'd65536;
  localparam int FracBits = 16;

  typedef enum logic [1:0] {
    CMD_WR_H   = 2'd0,
    CMD_WR_V   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_READ,
    ST_LERP,
    ST_DONE
  } state_t;

  // Register byte address of cell_size.
  localparam logic [0:0] REG_CELL_SIZE = 1'b0;
endpackage
`default_nettype wire

[rtl/sgvs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module sgvs_ram #(
  parameter int Width = 32,
  parameter int Depth = 4160
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

[rtl/sgvs_div.sv]
// Bit-serial floor divider: splits a signed coordinate by the cell size into a
// cell index and a Q0.16 weight, one quotient bit per cycle. Uses sgvs_pkg.
`default_nettype none
module sgvs_div
  import sgvs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] dividend,
  input  wire logic [30:0]        divisor,
  output logic                    done,
  output logic signed [32:0]      quot,
  output logic [FracBits-1:0]     wgt
);
  localparam int Steps = 32 + FracBits;

  logic [31:0]       dvd_r;
  logic [30:0]       rem_r;
  logic [30:0]       dsr_r;
  logic [Steps-1:0]  q_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic [31:0]       trial;
  logic              ge;
  logic [31:0]       qm;
  logic [FracBits-1:0] frac;
  logic              exact;
  logic [FracBits:0] wneg;

  assign trial = {rem_r, dvd_r[31]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(Steps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend[31] ? (32'd0 - dividend) : dividend;
      neg_r <= dividend[31];
      dsr_r <= (divisor == 31'd0) ? 31'd1 : divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= ge ? 31'(trial - {1'b0, dsr_r}) : trial[30:0];
      q_r   <= {q_r[Steps-2:0], ge};
    end
  end

  assign qm    = q_r[Steps-1:FracBits];
  assign frac  = q_r[FracBits-1:0];
  assign exact = (frac == '0) && (rem_r == '0);
  // A negative value that is not a whole number of cells steps down one cell and
  // takes the complementary weight, rounded down.
  assign wneg  = (FracBits+1)'(1 << FracBits) - {1'b0, frac}
               - {{FracBits{1'b0}}, (rem_r != '0)};

  always_comb begin
    if (!neg_r) begin
      quot = $signed({1'b0, qm});
      wgt  = frac;
    end else if (exact) begin
      quot = 33'sd0 - $signed({1'b0, qm});
      wgt  = '0;
    end else begin
      quot = 33'sd0 - $signed({1'b0, qm}) - 33'sd1;
      wgt  = wneg[FracBits-1:0];
    end
  end

  assign done = done_r;
endmodule
`default_nettype wire

[rtl/staggered_grid_velocity_sampler.sv]
// Top level of the staggered grid velocity sampler: face stores, sequencer,
// shared multiplier. Uses sgvs_pkg, sgvs_ram and sgvs_div.
//
//   channel | direction | handshake          | payload
//   in_     | in        | in_valid/in_stall  | cmd, col/row index, face value, coords
//   out_    | out       | out_valid/out_stall| vel_x, vel_y, bad_index
//   cfg_    | in        | APB psel/penable   | cell_size at byte address 0
//
// A write or unused command's result beat appears in the next cycle. A sample
// keeps the input stalled while it runs through two bit-serial divisions (48
// quotient steps each, 32 for the cell and 16 for the weight, then a done
// strobe), first for x and then for y, face reads through the single read port
// of each store, six lerps on the one shared multiplier, and a final state that
// loads the result. Reset is synchronous and clears only control state; the
// stores are undefined until written. The input stalls while a sample is in
// flight and while an unaccepted result beat is held.
`default_nettype none
module staggered_grid_velocity_sampler
  import sgvs_pkg::*;
#(
  parameter int GRID_W = DefGridW,
  parameter int GRID_H = DefGridH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [6:0]         in_col_index,
  input  wire logic [6:0]         in_row_index,
  input  wire logic signed [31:0] in_face_value,
  input  wire logic signed [31:0] in_coord_x,
  input  wire logic signed [31:0] in_coord_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_vel_x,
  output logic signed [31:0]      out_vel_y,
  output logic                    out_bad_index,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [0:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  localparam int HDepth = (GRID_W + 1) * GRID_H;
  localparam int VDepth = GRID_W * (GRID_H + 1);
  localparam int HAw = $clog2(HDepth);
  localparam int VAw = $clog2(VDepth);

  // Configuration register.
  logic [30:0] cell_size_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {1'b0, cell_size_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= CellSizeReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_CELL_SIZE) begin
      cell_size_r <= cfg_pwdata[30:0];
    end
  end

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic in_acc, out_acc;
  cmd_t cmd;

  assign cmd      = cmd_t'(in_cmd);
  assign in_stall = (state_r != ST_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // Divider shared by both coordinates.
  logic               div_start, div_done;
  logic signed [32:0] div_q;
  logic [15:0]        div_w;
  logic signed [31:0] coord_y_r;

  assign div_start = (in_acc && cmd == CMD_SAMPLE) || (state_r == ST_DIVX && div_done);

  sgvs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (state_r == ST_IDLE ? in_coord_x : coord_y_r),
    .divisor  (cell_size_r),
    .done     (div_done),
    .quot     (div_q),
    .wgt      (div_w)
  );

  logic signed [32:0] ci_r, cj_r;
  logic [15:0]        wx_r, wy_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      coord_y_r <= in_coord_y;
    end
    if (state_r == ST_DIVX && div_done) begin
      ci_r <= div_q;
      wx_r <= div_w;
    end
    if (state_r == ST_DIVY && div_done) begin
      cj_r <= div_q;
      wy_r <= div_w;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_SAMPLE) begin
          state_nxt = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          state_nxt = ST_READ;
          cnt_nxt   = '0;
        end
      end
      ST_READ: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd8) begin
          state_nxt = ST_LERP;
          cnt_nxt   = '0;
        end
      end
      ST_LERP: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd11) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Read addressing. Step k reads corner k/2; the even step takes the face at
  // the corner itself, the odd step the one below (horizontal) or to the left
  // (vertical). Corners run (i,j), (i+1,j), (i,j+1), (i+1,j+1).
  function automatic logic [10:0] clamp_idx(input logic signed [33:0] v, input int hi);
    logic [10:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 34'(hi)) begin
      r = 11'(hi);
    end else begin
      r = v[10:0];
    end
    return r;
  endfunction

  logic [1:0]         corner;
  logic               half;
  logic signed [33:0] ca, cb;
  logic [10:0]        hcol, hrow, vcol, vrow;
  logic [HAw-1:0]     h_raddr, h_waddr;
  logic [VAw-1:0]     v_raddr, v_waddr;
  logic               h_we, v_we, bad;
  logic [31:0]        h_rdata, v_rdata;

  assign corner = cnt_r[2:1];
  assign half   = cnt_r[0];
  assign ca     = 34'(ci_r) + {33'd0, corner[0]};
  assign cb     = 34'(cj_r) + {33'd0, corner[1]};
  assign hcol   = clamp_idx(ca, GRID_W);
  assign hrow   = clamp_idx(cb - {33'd0, half}, GRID_H - 1);
  assign vcol   = clamp_idx(ca - {33'd0, half}, GRID_W - 1);
  assign vrow   = clamp_idx(cb, GRID_H);
  assign h_raddr = HAw'(hcol) * HAw'(GRID_H) + HAw'(hrow);
  assign v_raddr = VAw'(vcol) * VAw'(GRID_H + 1) + VAw'(vrow);

  always_comb begin
    h_we = 1'b0;
    v_we = 1'b0;
    bad  = 1'b0;
    case (cmd)
      CMD_WR_H: begin
        if (11'(in_col_index) <= 11'(GRID_W) && 11'(in_row_index) < 11'(GRID_H)) begin
          h_we = in_acc;
        end else begin
          bad = 1'b1;
        end
      end
      CMD_WR_V: begin
        if (11'(in_col_index) < 11'(GRID_W) && 11'(in_row_index) <= 11'(GRID_H)) begin
          v_we = in_acc;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b0;
      end
    endcase
  end

  assign h_waddr = HAw'(in_col_index) * HAw'(GRID_H) + HAw'(in_row_index);
  assign v_waddr = VAw'(in_col_index) * VAw'(GRID_H + 1) + VAw'(in_row_index);

  sgvs_ram #(.Width(32), .Depth(HDepth)) u_hstore (
    .clk (clk), .we (h_we), .waddr (h_waddr), .wdata (in_face_value),
    .raddr (h_raddr), .rdata (h_rdata)
  );

  sgvs_ram #(.Width(32), .Depth(VDepth)) u_vstore (
    .clk (clk), .we (v_we), .waddr (v_waddr), .wdata (in_face_value),
    .raddr (v_raddr), .rdata (v_rdata)
  );

  // Read data arrives the cycle after its address; pair faces into corner values.
  logic [2:0]         rcnt_r;
  logic               rvalid_r;
  logic signed [31:0] h0_r, v0_r;
  logic signed [31:0] cu_r [4];
  logic signed [31:0] cv_r [4];
  logic signed [32:0] hsum, vsum;

  assign hsum = 33'($signed(h0_r)) + 33'($signed(h_rdata));
  assign vsum = 33'($signed(v0_r)) + 33'($signed(v_rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= (state_r == ST_READ) && (cnt_r != 4'd8);
    end
  end

  always_ff @(posedge clk) begin
    rcnt_r <= cnt_r[2:0];
    if (rvalid_r) begin
      if (!rcnt_r[0]) begin
        h0_r <= h_rdata;
        v0_r <= v_rdata;
      end else begin
        cu_r[rcnt_r[2:1]] <= hsum[32:1];
        cv_r[rcnt_r[2:1]] <= vsum[32:1];
      end
    end
  end

  // Shared multiplier: lerp = a + floor((b - a) * w / 2^16), each in a product step then a sum step.
  logic [2:0]         op;
  logic signed [31:0] la, lb;
  logic [15:0]        lw;
  logic signed [49:0] prod_r;
  logic signed [31:0] res_r [6];
  logic signed [33:0] lsum;

  assign op = cnt_r[3:1];

  always_comb begin
    case (op)
      3'd0: begin la = cu_r[0]; lb = cu_r[1]; lw = wx_r; end
      3'd1: begin la = cu_r[2]; lb = cu_r[3]; lw = wx_r; end
      3'd2: begin la = cv_r[0]; lb = cv_r[1]; lw = wx_r; end
      3'd3: begin la = cv_r[2]; lb = cv_r[3]; lw = wx_r; end
      3'd4: begin la = res_r[0]; lb = res_r[1]; lw = wy_r; end
      3'd5: begin la = res_r[2]; lb = res_r[3]; lw = wy_r; end
      default: begin la = '0; lb = '0; lw = '0; end
    endcase
  end

  assign lsum = 34'(la) + prod_r[49:16];

  always_ff @(posedge clk) begin
    if (state_r == ST_LERP) begin
      if (!cnt_r[0]) begin
        prod_r <= 50'((33'(lb) - 33'(la)) * $signed({1'b0, lw}));
      end else begin
        res_r[op] <= lsum[31:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (in_acc && cmd != CMD_SAMPLE) begin
      out_valid <= 1'b1;
    end else if (state_r == ST_DONE) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && cmd != CMD_SAMPLE) begin
      out_vel_x     <= '0;
      out_vel_y     <= '0;
      out_bad_index <= bad;
    end else if (state_r == ST_DONE) begin
      out_vel_x     <= res_r[4];
      out_vel_y     <= res_r[5];
      out_bad_index <= 1'b0;
    end
  end

  // A sample in flight keeps the input stalled.
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall)
    else $error("input not stalled while a sample is in flight");

  // Every accepted non-sample beat yields a result beat in the next cycle.
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && cmd != CMD_SAMPLE |=> out_valid)
    else $error("write beat produced no result");

  // The divider only finishes while the sequencer waits on it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVX || state_r == ST_DIVY))
    else $error("divider finished outside a division step");

  // The result slot is free when a sample result is loaded.
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> !out_valid)
    else $error("sample result would overwrite a held beat");
endmodule
`default_nettype wire
